### rtl/tobm_pkg.sv
// Shared types and constants for the obstacle brake monitor.
// No dependencies; imported by every module of the block.
package tobm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIST_W     = 15;
    localparam int COUNT_W    = 16;
    localparam int AGE_W      = 16;
    localparam int STREAK_W   = 8;

    localparam logic [DIST_W-1:0]  NONE_MM   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_SELECT    = 3'd0,
        REG_HEIGHT_MIN     = 3'd1,
        REG_HEIGHT_MAX     = 3'd2,
        REG_MIN_DISTANCE   = 3'd3,
        REG_STOP_DISTANCE  = 3'd4,
        REG_MIN_POINTS     = 3'd5,
        REG_CLEAR_FRAMES   = 3'd6,
        REG_FRAME_TIMEOUT  = 3'd7
    } t_reg_idx;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        logic [5:0]           axis_select;
        logic signed [15:0]   height_min_mm;
        logic signed [15:0]   height_max_mm;
        logic [DIST_W-1:0]    min_distance_mm;
        logic [DIST_W-1:0]    stop_distance_mm;
        logic [COUNT_W-1:0]   points_to_brake;
        logic [STREAK_W-1:0]  frames_to_clear;
        logic [AGE_W-1:0]     frame_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } t_judge;

    typedef struct packed {
        logic               brake_active;
        logic [COUNT_W-1:0] obstacle_count;
        logic [DIST_W-1:0]  nearest_mm;
        logic               data_stale;
    } t_result;

endpackage

### rtl/tof_obstacle_brake_monitor.sv
// Obstacle brake monitor top level: config registers, input and output stages.
// Depends on tobm_pkg, tobm_point_judge and tobm_frame_ctrl.
//
// Input channel (i_in_valid / o_in_ready) carries either a point (x, y, z in mm
// and a last-of-frame flag) or a tick of elapsed time. Every transfer yields
// exactly one result on the output channel (o_out_valid / i_out_ready): brake
// state, latched frame count and nearest distance, and the stale flag.
// The input register feeds the result register, whose valid flag is o_out_valid.
// Throughput: one item per cycle while the receiver does not stall; the point
// window check and the frame update are both done combinationally between the
// input register and the result register.
// A stalled receiver holds the result register; the input register still takes
// one more item, then o_in_ready drops until the result is transferred.
// Config writes (i_cfg_wr_en, i_cfg_index, i_cfg_data) take effect at once and
// are expected only while the block is idle.
// Reset (synchronous, active low) restores register defaults, clears the frame
// statistics and engages the brake; with a nonzero timeout every item reports
// stale until the first frame completes.
module tof_obstacle_brake_monitor #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tobm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tobm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic signed [COORD_BITS-1:0]   i_point_x,
    input  logic signed [COORD_BITS-1:0]   i_point_y,
    input  logic signed [COORD_BITS-1:0]   i_point_z,
    input  logic                           i_last_point,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_brake_active,
    output logic [tobm_pkg::COUNT_W-1:0]   o_obstacle_count,
    output logic [tobm_pkg::DIST_W-1:0]    o_nearest_mm,
    output logic                           o_data_stale
);
    import tobm_pkg::*;

    t_cfg                         r_cfg;
    logic                         r_in_valid;
    logic                         r_opcode;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic                         r_last;
    logic                         r_out_valid;
    logic                         adv;
    t_judge                       judge;
    t_result                      result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_select         <= 6'd42;
            r_cfg.height_min_mm       <= -16'sd100;
            r_cfg.height_max_mm       <= 16'sd100;
            r_cfg.min_distance_mm     <= DIST_W'(30);
            r_cfg.stop_distance_mm    <= DIST_W'(100);
            r_cfg.points_to_brake     <= COUNT_W'(8);
            r_cfg.frames_to_clear     <= STREAK_W'(3);
            r_cfg.frame_timeout_ticks <= AGE_W'(2000);
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_AXIS_SELECT:   r_cfg.axis_select         <= i_cfg_data[5:0];
                REG_HEIGHT_MIN:    r_cfg.height_min_mm       <= i_cfg_data;
                REG_HEIGHT_MAX:    r_cfg.height_max_mm       <= i_cfg_data;
                REG_MIN_DISTANCE:  r_cfg.min_distance_mm     <= i_cfg_data[DIST_W-1:0];
                REG_STOP_DISTANCE: r_cfg.stop_distance_mm    <= i_cfg_data[DIST_W-1:0];
                REG_MIN_POINTS:    r_cfg.points_to_brake     <= i_cfg_data[COUNT_W-1:0];
                REG_CLEAR_FRAMES:  r_cfg.frames_to_clear     <= i_cfg_data[STREAK_W-1:0];
                REG_FRAME_TIMEOUT: r_cfg.frame_timeout_ticks <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode <= i_opcode;
            r_x      <= i_point_x;
            r_y      <= i_point_y;
            r_z      <= i_point_z;
            r_last   <= i_last_point;
        end
    end

    tobm_point_judge #(
        .COORD_BITS (COORD_BITS)
    ) u_judge (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_z     (r_z),
        .i_cfg   (r_cfg),
        .o_judge (judge)
    );

    tobm_frame_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_opcode     (r_opcode),
        .i_last_point (r_last),
        .i_judge      (judge),
        .i_cfg        (r_cfg),
        .o_result     (result)
    );

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_brake_active   = result.brake_active;
    assign o_obstacle_count = result.obstacle_count;
    assign o_nearest_mm     = result.nearest_mm;
    assign o_data_stale     = result.data_stale;

endmodule

### rtl/tobm_point_judge.sv
// Per-point check: axis selection, negation, z > 0, height and distance windows.
// Depends on tobm_pkg. Purely combinational.
module tobm_point_judge #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  tobm_pkg::t_cfg               i_cfg,
    output tobm_pkg::t_judge             o_judge
);
    import tobm_pkg::*;

    localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

    logic signed [CW-1:0] x_w, y_w, z_w;
    logic signed [CW-1:0] h_val, d_val;
    logic signed [CW-1:0] hmin_w, hmax_w, lo, hi;
    logic signed [CW-1:0] dmin_w, dmax_w;
    logic                 z_pos;

    function automatic logic signed [CW-1:0] pick(
        input logic [1:0]           sel,
        input logic                 neg,
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] c
    );
        logic signed [CW-1:0] v;
        case (t_axis'(sel))
            AXIS_X:  v = a;
            AXIS_Y:  v = b;
            AXIS_Z:  v = c;
            default: v = '0;
        endcase
        return neg ? -v : v;
    endfunction

    always_comb begin
        x_w    = CW'(i_x);
        y_w    = CW'(i_y);
        z_w    = CW'(i_z);
        hmin_w = CW'($signed(i_cfg.height_min_mm));
        hmax_w = CW'($signed(i_cfg.height_max_mm));
        dmin_w = CW'({1'b0, i_cfg.min_distance_mm});
        dmax_w = CW'({1'b0, i_cfg.stop_distance_mm});
        // reversed window: swap ends
        if (hmax_w < hmin_w) begin
            lo = hmax_w;
            hi = hmin_w;
        end else begin
            lo = hmin_w;
            hi = hmax_w;
        end
        h_val = pick(i_cfg.axis_select[4:3], i_cfg.axis_select[5], x_w, y_w, z_w);
        d_val = pick(i_cfg.axis_select[1:0], i_cfg.axis_select[2], x_w, y_w, z_w);
        z_pos = !i_z[COORD_BITS-1] && (i_z != '0);
        o_judge.hit      = z_pos && (h_val >= lo) && (h_val <= hi)
                           && (d_val >= dmin_w) && (d_val <= dmax_w);
        o_judge.distance = d_val[DIST_W-1:0];
    end

endmodule

### rtl/tobm_frame_ctrl.sv
// Frame statistics, frame age, stale check and brake state, plus result register.
// Depends on tobm_pkg; fed by tobm_point_judge through the top level.
module tobm_frame_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_opcode,
    input  logic                      i_last_point,
    input  tobm_pkg::t_judge          i_judge,
    input  tobm_pkg::t_cfg            i_cfg,
    output tobm_pkg::t_result         o_result
);
    import tobm_pkg::*;

    logic [COUNT_W-1:0]  r_run_count, n_run_count;
    logic [DIST_W-1:0]   r_run_near, n_run_near;
    logic [COUNT_W-1:0]  r_lat_count, n_lat_count;
    logic [DIST_W-1:0]   r_lat_near, n_lat_near;
    logic                r_seen, n_seen;
    logic [AGE_W-1:0]    r_age, n_age;
    logic [STREAK_W-1:0] r_streak, n_streak;
    logic                r_brake, n_brake;
    t_result             r_result, n_result;

    logic [COUNT_W-1:0]  acc_count;
    logic [DIST_W-1:0]   acc_near;
    logic [COUNT_W-1:0]  need_pts;
    logic [STREAK_W-1:0] need_clear;
    logic [STREAK_W:0]   streak_inc;
    logic                is_tick, completed, stale;

    always_comb begin
        is_tick    = (t_opcode'(i_opcode) == OP_TICK);
        completed  = !is_tick && i_last_point;
        need_pts   = (i_cfg.points_to_brake == '0) ? COUNT_W'(1)
                                                   : i_cfg.points_to_brake;
        need_clear = (i_cfg.frames_to_clear == '0) ? STREAK_W'(1)
                                                   : i_cfg.frames_to_clear;

        acc_count = r_run_count;
        acc_near  = r_run_near;
        if (!is_tick && i_judge.hit) begin
            if (r_run_count != COUNT_MAX)
                acc_count = r_run_count + COUNT_W'(1);
            if (i_judge.distance < r_run_near)
                acc_near = i_judge.distance;
        end

        n_run_count = acc_count;
        n_run_near  = acc_near;
        n_lat_count = r_lat_count;
        n_lat_near  = r_lat_near;
        n_seen      = r_seen;
        n_age       = r_age;
        if (is_tick) begin
            if (r_age != AGE_MAX)
                n_age = r_age + AGE_W'(1);
        end else if (completed) begin
            n_lat_count = acc_count;
            n_lat_near  = acc_near;
            n_run_count = '0;
            n_run_near  = NONE_MM;
            n_seen      = 1'b1;
            n_age       = '0;
        end

        stale = (i_cfg.frame_timeout_ticks != '0)
                && (!n_seen || (n_age > i_cfg.frame_timeout_ticks));

        streak_inc = {1'b0, r_streak} + (STREAK_W+1)'(1);
        n_streak   = r_streak;
        n_brake    = r_brake;
        if (stale) begin
            n_streak = '0;
            n_brake  = 1'b1;
        end else if (completed) begin
            if (n_lat_count >= need_pts) begin
                n_streak = '0;
                n_brake  = 1'b1;
            end else if (streak_inc < {1'b0, need_clear}) begin
                n_streak = streak_inc[STREAK_W-1:0];
            end else begin
                n_streak = need_clear;
                n_brake  = 1'b0;
            end
        end

        n_result.brake_active   = n_brake;
        n_result.obstacle_count = n_lat_count;
        n_result.nearest_mm     = n_lat_near;
        n_result.data_stale     = stale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= '0;
            r_run_near  <= NONE_MM;
            r_lat_count <= '0;
            r_lat_near  <= NONE_MM;
            r_seen      <= 1'b0;
            r_age       <= '0;
            r_streak    <= '0;
            r_brake     <= 1'b1;
        end else if (i_en) begin
            r_run_count <= n_run_count;
            r_run_near  <= n_run_near;
            r_lat_count <= n_lat_count;
            r_lat_near  <= n_lat_near;
            r_seen      <= n_seen;
            r_age       <= n_age;
            r_streak    <= n_streak;
            r_brake     <= n_brake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
